>>> hw/rtl/epcsv_pkg.sv
// Shared types and constants of the edge-pair CSV parser.
package epcsv_pkg;

  localparam int unsigned LINE_COUNT_BITS = 32;
  localparam int unsigned ROW_COUNT_BITS  = 32;

  // Result queue depth (power of two, at least two results per word)
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_EDGE    = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_HEADER, PH_HEADER_CR, PH_FIRST_LEAD, PH_FIRST_NEED, PH_FIRST_DIG,
    PH_FIRST_TRAIL, PH_SECOND_LEAD, PH_SECOND_NEED, PH_SECOND_DIG,
    PH_SECOND_TRAIL, PH_ROW_CR, PH_FINISHED, PH_FAILED
  } phase_e;

  localparam logic [4:0] ERR_NONE          = 5'd0;
  localparam logic [4:0] ERR_BOM           = 5'd1;
  localparam logic [4:0] ERR_HDR_BYTE      = 5'd2;
  localparam logic [4:0] ERR_AFTER_HDR     = 5'd3;
  localparam logic [4:0] ERR_LONE_CR       = 5'd4;
  localparam logic [4:0] ERR_NONCANON      = 5'd5;
  localparam logic [4:0] ERR_OVERFLOW      = 5'd6;
  localparam logic [4:0] ERR_BLANK_LINE    = 5'd7;
  localparam logic [4:0] ERR_MISSING_SRC   = 5'd8;
  localparam logic [4:0] ERR_QUOTE         = 5'd9;
  localparam logic [4:0] ERR_INVALID_SRC   = 5'd10;
  localparam logic [4:0] ERR_MINUS_ALONE   = 5'd11;
  localparam logic [4:0] ERR_MISSING_DFLD  = 5'd12;
  localparam logic [4:0] ERR_JUNK_SRC      = 5'd13;
  localparam logic [4:0] ERR_EXTRA_FIELD   = 5'd14;
  localparam logic [4:0] ERR_MISSING_DST   = 5'd15;
  localparam logic [4:0] ERR_INVALID_DST   = 5'd16;
  localparam logic [4:0] ERR_JUNK_DST      = 5'd17;
  localparam logic [4:0] ERR_ROW_OVF       = 5'd18;
  localparam logic [4:0] ERR_LINE_OVF      = 5'd19;
  localparam logic [4:0] ERR_EMPTY         = 5'd20;
  localparam logic [4:0] ERR_NO_HEADER     = 5'd21;
  localparam logic [4:0] ERR_BAD_LAST      = 5'd22;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] edge_from;
    logic [31:0] edge_to;
    logic [31:0] line_number;
    logic [4:0]  error_code;
    logic [31:0] rows_delivered;
    logic        is_last;
  } result_t;

  // Results produced by one accepted word, r0 first
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> hw/rtl/epcsv_core.sv
// Parser state machine: one word per cycle while step_i is high, up to two results.
module epcsv_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             func_i,
  input  logic [7:0]       in_byte_i,
  output epcsv_pkg::push_t push_o
);

  localparam int unsigned LCB = epcsv_pkg::LINE_COUNT_BITS;
  localparam int unsigned RCB = epcsv_pkg::ROW_COUNT_BITS;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [34:0] POS_LIMIT = 35'd2147483647;
  localparam logic [34:0] NEG_LIMIT = 35'd2147483648;

  typedef struct packed {
    logic [4:0]  code;
    logic        seen;
    logic        fdz;
    logic [31:0] acc;
  } digit_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h66; // f
      3'd1:    c = 8'h72; // r
      3'd2:    c = 8'h6F; // o
      3'd3:    c = 8'h6D; // m
      3'd4:    c = 8'h2C; // ,
      3'd5:    c = 8'h74; // t
      3'd6:    c = 8'h6F; // o
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Accumulate one decimal digit with canonical-form and range checks
  function automatic digit_t digit_step(input logic neg, input logic seen,
                                        input logic fdz, input logic [31:0] acc,
                                        input logic [3:0] d);
    digit_t      r;
    logic [34:0] prod;
    logic [34:0] limit;
    prod  = {acc, 3'b000} + {2'b00, acc, 1'b0} + {31'd0, d};
    limit = neg ? NEG_LIMIT : POS_LIMIT;
    r.code = epcsv_pkg::ERR_NONE;
    r.seen = seen;
    r.fdz  = fdz;
    r.acc  = acc;
    if (!seen) begin
      if (neg && d == 4'd0) begin
        r.code = epcsv_pkg::ERR_NONCANON;
      end else begin
        r.seen = 1'b1;
        r.fdz  = (d == 4'd0);
      end
    end else if (fdz) begin
      r.code = epcsv_pkg::ERR_NONCANON;
    end
    if (r.code == epcsv_pkg::ERR_NONE) begin
      if (prod > limit) begin
        r.code = epcsv_pkg::ERR_OVERFLOW;
      end else begin
        r.acc = prod[31:0];
      end
    end
    return r;
  endfunction

  epcsv_pkg::phase_e phase_q, phase_d;
  logic [2:0]     hdr_pos_q, hdr_pos_d;
  logic [LCB-1:0] line_cnt_q, line_cnt_d;
  logic [RCB-1:0] row_cnt_q, row_cnt_d;
  logic           row_started_q, row_started_d;
  logic           neg_q, neg_d;
  logic           seen_q, seen_d;
  logic           fdz_q, fdz_d;
  logic [31:0]    acc_q, acc_d;
  logic [31:0]    held_src_q, held_src_d;
  logic [31:0]    held_dst_q, held_dst_d;

  logic        is_dig, is_pad, is_nl;
  logic [3:0]  dval;
  logic [31:0] num_val;
  digit_t      dig_cont, dig_new, dig_sel;
  logic        do_digit, dig_fresh, do_endline, do_end_deliver;
  logic        fail, line_two, emit_edge, emit_sum;
  logic [4:0]  fail_code;
  logic [31:0] line_lo, rows_lo;

  assign is_dig  = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE);
  assign is_pad  = (in_byte_i == CH_SP) || (in_byte_i == CH_TAB);
  assign is_nl   = (in_byte_i == CH_LF) || (in_byte_i == CH_CR);
  assign dval    = 4'(in_byte_i - CH_ZERO);
  assign num_val = neg_q ? (32'd0 - acc_q) : acc_q;
  assign dig_cont = digit_step(neg_q, seen_q, fdz_q, acc_q, dval);
  assign dig_new  = digit_step(1'b0, 1'b0, 1'b0, 32'd0, dval);

  always_comb begin
    phase_d        = phase_q;
    hdr_pos_d      = hdr_pos_q;
    line_cnt_d     = line_cnt_q;
    row_cnt_d      = row_cnt_q;
    row_started_d  = row_started_q;
    neg_d          = neg_q;
    seen_d         = seen_q;
    fdz_d          = fdz_q;
    acc_d          = acc_q;
    held_src_d     = held_src_q;
    held_dst_d     = held_dst_q;
    do_digit       = 1'b0;
    dig_fresh      = 1'b0;
    do_endline     = 1'b0;
    do_end_deliver = 1'b0;
    fail           = 1'b0;
    fail_code      = epcsv_pkg::ERR_NONE;
    line_two       = 1'b0;
    emit_edge      = 1'b0;
    emit_sum       = 1'b0;
    dig_sel        = dig_cont;

    if (step_i && !func_i) begin
      case (phase_q)
        epcsv_pkg::PH_HEADER: begin
          if (hdr_pos_q != 3'd7) begin
            if (hdr_pos_q == 3'd0 && in_byte_i == CH_BOM0) begin
              fail = 1'b1; fail_code = epcsv_pkg::ERR_BOM;
            end else if (in_byte_i != hdr_char(hdr_pos_q)) begin
              fail = 1'b1; fail_code = epcsv_pkg::ERR_HDR_BYTE;
            end else begin
              hdr_pos_d = hdr_pos_q + 3'd1;
            end
          end else if (in_byte_i == CH_LF) begin
            line_cnt_d    = LCB'(2);
            row_started_d = 1'b0;
            phase_d       = epcsv_pkg::PH_FIRST_LEAD;
          end else if (in_byte_i == CH_CR) begin
            phase_d = epcsv_pkg::PH_HEADER_CR;
          end else begin
            fail = 1'b1; fail_code = epcsv_pkg::ERR_AFTER_HDR;
          end
        end
        epcsv_pkg::PH_HEADER_CR: begin
          if (in_byte_i != CH_LF) begin
            fail = 1'b1; fail_code = epcsv_pkg::ERR_LONE_CR;
          end else begin
            line_cnt_d    = LCB'(2);
            row_started_d = 1'b0;
            phase_d       = epcsv_pkg::PH_FIRST_LEAD;
          end
        end
        epcsv_pkg::PH_FIRST_LEAD, epcsv_pkg::PH_SECOND_LEAD: begin
          if (phase_q == epcsv_pkg::PH_FIRST_LEAD) begin
            row_started_d = 1'b1;
          end
          if (is_pad) begin
            // stay
          end else if (in_byte_i == CH_MINUS) begin
            neg_d   = 1'b1;
            seen_d  = 1'b0;
            fdz_d   = 1'b0;
            acc_d   = 32'd0;
            phase_d = (phase_q == epcsv_pkg::PH_FIRST_LEAD) ?
                      epcsv_pkg::PH_FIRST_NEED : epcsv_pkg::PH_SECOND_NEED;
          end else if (is_dig) begin
            neg_d     = 1'b0;
            do_digit  = 1'b1;
            dig_fresh = 1'b1;
            phase_d   = (phase_q == epcsv_pkg::PH_FIRST_LEAD) ?
                        epcsv_pkg::PH_FIRST_DIG : epcsv_pkg::PH_SECOND_DIG;
          end else if (phase_q == epcsv_pkg::PH_FIRST_LEAD) begin
            fail = 1'b1;
            if (is_nl)                        fail_code = epcsv_pkg::ERR_BLANK_LINE;
            else if (in_byte_i == CH_COMMA)   fail_code = epcsv_pkg::ERR_MISSING_SRC;
            else if (in_byte_i == CH_QUOTE)   fail_code = epcsv_pkg::ERR_QUOTE;
            else                              fail_code = epcsv_pkg::ERR_INVALID_SRC;
          end else begin
            fail = 1'b1;
            if (in_byte_i == CH_COMMA)        fail_code = epcsv_pkg::ERR_EXTRA_FIELD;
            else if (is_nl)                   fail_code = epcsv_pkg::ERR_MISSING_DST;
            else if (in_byte_i == CH_QUOTE)   fail_code = epcsv_pkg::ERR_QUOTE;
            else                              fail_code = epcsv_pkg::ERR_INVALID_DST;
          end
        end
        epcsv_pkg::PH_FIRST_NEED, epcsv_pkg::PH_SECOND_NEED: begin
          if (!is_dig) begin
            fail = 1'b1; fail_code = epcsv_pkg::ERR_MINUS_ALONE;
          end else begin
            do_digit = 1'b1;
            phase_d  = (phase_q == epcsv_pkg::PH_FIRST_NEED) ?
                       epcsv_pkg::PH_FIRST_DIG : epcsv_pkg::PH_SECOND_DIG;
          end
        end
        epcsv_pkg::PH_FIRST_DIG, epcsv_pkg::PH_FIRST_TRAIL: begin
          if (phase_q == epcsv_pkg::PH_FIRST_DIG && is_dig) begin
            do_digit = 1'b1;
          end else begin
            if (phase_q == epcsv_pkg::PH_FIRST_DIG) begin
              held_src_d = num_val;
            end
            if (in_byte_i == CH_COMMA) begin
              phase_d = epcsv_pkg::PH_SECOND_LEAD;
            end else if (is_pad) begin
              phase_d = epcsv_pkg::PH_FIRST_TRAIL;
            end else if (is_nl) begin
              fail = 1'b1; fail_code = epcsv_pkg::ERR_MISSING_DFLD;
            end else begin
              fail = 1'b1; fail_code = epcsv_pkg::ERR_JUNK_SRC;
            end
          end
        end
        epcsv_pkg::PH_SECOND_DIG, epcsv_pkg::PH_SECOND_TRAIL: begin
          if (phase_q == epcsv_pkg::PH_SECOND_DIG && is_dig) begin
            do_digit = 1'b1;
          end else begin
            if (phase_q == epcsv_pkg::PH_SECOND_DIG) begin
              held_dst_d = num_val;
            end
            if (is_pad) begin
              phase_d = epcsv_pkg::PH_SECOND_TRAIL;
            end else if (in_byte_i == CH_LF) begin
              do_endline = 1'b1;
            end else if (in_byte_i == CH_CR) begin
              phase_d = epcsv_pkg::PH_ROW_CR;
            end else if (in_byte_i == CH_COMMA) begin
              fail = 1'b1; fail_code = epcsv_pkg::ERR_EXTRA_FIELD;
            end else begin
              fail = 1'b1; fail_code = epcsv_pkg::ERR_JUNK_DST;
            end
          end
        end
        epcsv_pkg::PH_ROW_CR: begin
          if (in_byte_i != CH_LF) begin
            fail = 1'b1; fail_code = epcsv_pkg::ERR_LONE_CR;
          end else begin
            do_endline = 1'b1;
          end
        end
        default: begin
          // stopped: drop the word
        end
      endcase
    end else if (step_i && func_i) begin
      case (phase_q)
        epcsv_pkg::PH_HEADER: begin
          fail = 1'b1;
          if (hdr_pos_q == 3'd7) begin
            fail_code = epcsv_pkg::ERR_EMPTY;
            line_two  = 1'b1;
          end else begin
            fail_code = epcsv_pkg::ERR_NO_HEADER;
          end
        end
        epcsv_pkg::PH_HEADER_CR, epcsv_pkg::PH_ROW_CR: begin
          fail = 1'b1; fail_code = epcsv_pkg::ERR_LONE_CR;
        end
        epcsv_pkg::PH_FIRST_LEAD: begin
          if (row_started_q) begin
            fail = 1'b1; fail_code = epcsv_pkg::ERR_BAD_LAST;
          end else if (row_cnt_q == '0) begin
            fail = 1'b1; fail_code = epcsv_pkg::ERR_EMPTY;
          end else begin
            emit_sum = 1'b1;
            phase_d  = epcsv_pkg::PH_FINISHED;
          end
        end
        epcsv_pkg::PH_FIRST_NEED, epcsv_pkg::PH_SECOND_NEED: begin
          fail = 1'b1; fail_code = epcsv_pkg::ERR_MINUS_ALONE;
        end
        epcsv_pkg::PH_FIRST_DIG, epcsv_pkg::PH_FIRST_TRAIL: begin
          fail = 1'b1; fail_code = epcsv_pkg::ERR_MISSING_DFLD;
        end
        epcsv_pkg::PH_SECOND_LEAD: begin
          fail = 1'b1; fail_code = epcsv_pkg::ERR_MISSING_DST;
        end
        epcsv_pkg::PH_SECOND_DIG, epcsv_pkg::PH_SECOND_TRAIL: begin
          if (phase_q == epcsv_pkg::PH_SECOND_DIG) begin
            held_dst_d = num_val;
          end
          do_end_deliver = 1'b1;
        end
        default: begin
          // stopped: drop the word
        end
      endcase
    end

    if (do_digit) begin
      dig_sel = dig_fresh ? dig_new : dig_cont;
      if (dig_sel.code != epcsv_pkg::ERR_NONE) begin
        fail      = 1'b1;
        fail_code = dig_sel.code;
      end else begin
        seen_d = dig_sel.seen;
        fdz_d  = dig_sel.fdz;
        acc_d  = dig_sel.acc;
      end
    end

    if (do_endline) begin
      if (line_cnt_q == '1) begin
        fail = 1'b1; fail_code = epcsv_pkg::ERR_LINE_OVF;
      end else if (row_cnt_q == '1) begin
        fail = 1'b1; fail_code = epcsv_pkg::ERR_ROW_OVF;
      end else begin
        emit_edge     = 1'b1;
        row_cnt_d     = row_cnt_q + RCB'(1);
        line_cnt_d    = line_cnt_q + LCB'(1);
        row_started_d = 1'b0;
        phase_d       = epcsv_pkg::PH_FIRST_LEAD;
      end
    end

    if (do_end_deliver) begin
      if (row_cnt_q == '1) begin
        fail = 1'b1; fail_code = epcsv_pkg::ERR_ROW_OVF;
      end else begin
        emit_edge = 1'b1;
        emit_sum  = 1'b1;
        row_cnt_d = row_cnt_q + RCB'(1);
        phase_d   = epcsv_pkg::PH_FINISHED;
      end
    end

    if (fail) begin
      phase_d = epcsv_pkg::PH_FAILED;
    end
  end

  assign line_lo = 32'(64'(line_cnt_q));
  assign rows_lo = 32'(64'(row_cnt_d));

  // Assemble results: an edge comes first; a summary may follow it
  always_comb begin
    push_o.v0 = emit_edge || emit_sum || fail;
    push_o.v1 = emit_edge && emit_sum;

    push_o.r0.edge_from      = 32'd0;
    push_o.r0.edge_to        = 32'd0;
    push_o.r0.line_number    = 32'd0;
    push_o.r0.error_code     = epcsv_pkg::ERR_NONE;
    push_o.r0.rows_delivered = 32'd0;
    push_o.r0.is_last        = !(emit_edge && emit_sum);
    if (emit_edge) begin
      push_o.r0.kind        = epcsv_pkg::KIND_EDGE;
      push_o.r0.edge_from   = held_src_d;
      push_o.r0.edge_to     = held_dst_d;
      push_o.r0.line_number = line_lo;
    end else if (fail) begin
      push_o.r0.kind        = epcsv_pkg::KIND_ERROR;
      push_o.r0.line_number = line_two ? 32'd2 : line_lo;
      push_o.r0.error_code  = fail_code;
    end else begin
      push_o.r0.kind           = epcsv_pkg::KIND_SUMMARY;
      push_o.r0.rows_delivered = rows_lo;
    end

    push_o.r1.kind           = epcsv_pkg::KIND_SUMMARY;
    push_o.r1.edge_from      = 32'd0;
    push_o.r1.edge_to        = 32'd0;
    push_o.r1.line_number    = 32'd0;
    push_o.r1.error_code     = epcsv_pkg::ERR_NONE;
    push_o.r1.rows_delivered = rows_lo;
    push_o.r1.is_last        = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= epcsv_pkg::PH_HEADER;
      hdr_pos_q     <= 3'd0;
      line_cnt_q    <= LCB'(1);
      row_cnt_q     <= '0;
      row_started_q <= 1'b0;
      neg_q         <= 1'b0;
      seen_q        <= 1'b0;
      fdz_q         <= 1'b0;
      acc_q         <= 32'd0;
      held_src_q    <= 32'd0;
      held_dst_q    <= 32'd0;
    end else begin
      phase_q       <= phase_d;
      hdr_pos_q     <= hdr_pos_d;
      line_cnt_q    <= line_cnt_d;
      row_cnt_q     <= row_cnt_d;
      row_started_q <= row_started_d;
      neg_q         <= neg_d;
      seen_q        <= seen_d;
      fdz_q         <= fdz_d;
      acc_q         <= acc_d;
      held_src_q    <= held_src_d;
      held_dst_q    <= held_dst_d;
    end
  end

endmodule

>>> hw/rtl/epcsv_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready_i is high.
module epcsv_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  epcsv_pkg::push_t     push_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output epcsv_pkg::result_t   out_o
);

  localparam int unsigned DEPTH = epcsv_pkg::FIFO_DEPTH;
  localparam int unsigned PW    = epcsv_pkg::FIFO_PTR_W;
  localparam int unsigned CW    = epcsv_pkg::FIFO_CNT_W;

  epcsv_pkg::result_t slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] wr_ptr_nxt;
  logic [1:0]    n_push;
  logic          pop;

  assign wr_ptr_nxt  = wr_ptr_q + PW'(1);
  assign n_push      = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = slot_q[rd_ptr_q];
  // Room for the largest burst one word can cause
  assign space_o     = (cnt_q <= CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      slot_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      slot_q[wr_ptr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/edge_pair_csv_parser.sv
// Top level of the edge-pair CSV parser: stream ports, parser core, result queue.
//
//   channel  dir  tdata                              tuser       tlast
//   s_axis   in   in_byte[7:0]                       func        -
//   m_axis   out  edge_from, edge_to, line_number,   kind[1:0]   is_last
//                 error_code, rows_delivered
//
// One word is taken per cycle while s_axis_tready_o is high; each word is fully
// parsed in the cycle it is accepted, and its results land in a four-entry queue
// on the next edge. A result then reaches m_axis from the queue, behind older ones.
// End of input inside an unterminated last row yields two results (edge, summary);
// s_axis_tready_o drops only while the queue lacks room for two results.
// After an error or a summary, words are still accepted and dropped until reset.
// Reset puts the parser at the start of the header and empties the queue.
module edge_pair_csv_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input words
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // [7:0] in_byte
  input  logic          s_axis_tuser_i,   // [0] func: 1 = end of input
  // Result words
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] edge_from, [63:32] edge_to, [95:64] line_number,
  // [100:96] error_code, [132:101] rows_delivered, [135:133] zero
  output logic [135:0]  m_axis_tdata_o,
  output logic [1:0]    m_axis_tuser_o,   // [1:0] kind
  output logic          m_axis_tlast_o    // last result of the input word
);

  epcsv_pkg::push_t   push;
  epcsv_pkg::result_t head;
  logic               space;
  logic               accept;

  // Accept whenever the queue can absorb a worst-case burst
  assign s_axis_tready_o = space;
  assign accept          = s_axis_tvalid_i && space;

  epcsv_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .func_i    (s_axis_tuser_i),
    .in_byte_i (s_axis_tdata_i),
    .push_o    (push)
  );

  epcsv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (head)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata_o = {3'b000, head.rows_delivered, head.error_code,
                           head.line_number, head.edge_to, head.edge_from};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.is_last;

endmodule

>>> test/tb_top.sv
// Stream-level testbench of edge_pair_csv_parser with a built-in parser predictor.
module tb_top;
  import epcsv_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung;
  // covers the long sink hold-off several times over.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned PHASE_WORDS     = 400;

  // Input word kinds carried on tuser
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Bytes that steer the parser
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BOM   = 8'hEF;

  localparam logic [55:0] HEADER_TEXT = "from,to";
  localparam int unsigned HEADER_LEN  = 7;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  edge_pair_csv_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial forever #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser predictor: its own copy of the parse state, starting at reset values
  // ---------------------------------------------------------------------------
  phase_e                     parse_ph      = PH_HEADER;
  int unsigned                hdr_idx       = 0;
  logic [LINE_COUNT_BITS-1:0] line_no       = 1;
  logic [ROW_COUNT_BITS-1:0]  row_no        = 0;
  bit                         row_open      = 1'b0;
  bit                         num_neg       = 1'b0;
  bit                         num_has_digit = 1'b0;
  bit                         num_lead_zero = 1'b0;
  longint unsigned            num_mag       = 0;
  logic [31:0]                src_val       = '0;
  logic [31:0]                dst_val       = '0;

  result_t word_results[$];   // results of the word being parsed
  result_t results_due[$];    // results still to come out of the block, oldest first

  // Stimulus knobs and run statistics
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int          hold_left      = 0;
  int unsigned words_sent     = 0;
  int unsigned edges_seen     = 0;
  int unsigned errors_seen    = 0;
  int unsigned summaries_seen = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  function automatic bit digit_byte(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_pad(logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  function automatic void emit(kind_e k, logic [31:0] from_v, logic [31:0] to_v,
                               logic [31:0] line_v, logic [4:0] code, logic [31:0] rows_v);
    result_t r;
    r = '0;
    r.kind           = k;
    r.edge_from      = from_v;
    r.edge_to        = to_v;
    r.line_number    = line_v;
    r.error_code     = code;
    r.rows_delivered = rows_v;
    word_results.push_back(r);
  endfunction

  // Any violation reports the current line and stops the parser for good
  function automatic void raise_error(logic [4:0] code);
    parse_ph = PH_FAILED;
    emit(KIND_ERROR, '0, '0, 32'(line_no), code, '0);
  endfunction

  function automatic void open_number(bit neg, phase_e next);
    num_neg       = neg;
    num_has_digit = 1'b0;
    num_lead_zero = 1'b0;
    num_mag       = 0;
    parse_ph      = next;
  endfunction

  // Accumulate one decimal digit; reject leading zeros, minus zero and int32 overflow
  function automatic void take_digit(logic [7:0] b);
    longint unsigned d;
    longint unsigned lim;
    d = b - CH_ZERO;
    if (!num_has_digit) begin
      if (num_neg && d == 0) begin
        raise_error(ERR_NONCANON);
        return;
      end
      num_has_digit = 1'b1;
      num_lead_zero = (d == 0);
    end else if (num_lead_zero) begin
      raise_error(ERR_NONCANON);
      return;
    end
    lim = num_neg ? 64'd2147483648 : 64'd2147483647;
    if (num_mag > (lim - d) / 10) begin
      raise_error(ERR_OVERFLOW);
      return;
    end
    num_mag = num_mag * 10 + d;
  endfunction

  function automatic logic [31:0] number_value();
    logic [31:0] m;
    m = num_mag[31:0];
    return num_neg ? -m : m;
  endfunction

  function automatic void deliver_row();
    if (row_no == '1) begin
      raise_error(ERR_ROW_OVF);
      return;
    end
    emit(KIND_EDGE, src_val, dst_val, 32'(line_no), ERR_NONE, '0);
    row_no++;
  endfunction

  function automatic void close_line();
    if (line_no == '1) begin
      raise_error(ERR_LINE_OVF);
      return;
    end
    deliver_row();
    if (parse_ph == PH_FAILED) return;
    line_no++;
    row_open = 1'b0;
    parse_ph = PH_FIRST_LEAD;
  endfunction

  function automatic void open_data();
    line_no  = 2;
    row_open = 1'b0;
    parse_ph = PH_FIRST_LEAD;
  endfunction

  function automatic void finish_run();
    parse_ph = PH_FINISHED;
    emit(KIND_SUMMARY, '0, '0, '0, ERR_NONE, 32'(row_no));
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (parse_ph)
      PH_HEADER: begin
        if (hdr_idx < HEADER_LEN) begin
          if (hdr_idx == 0 && b == CH_BOM) raise_error(ERR_BOM);
          else if (b != HEADER_TEXT[8*(HEADER_LEN-1-hdr_idx) +: 8]) raise_error(ERR_HDR_BYTE);
          else hdr_idx++;
        end else if (b == CH_LF) open_data();
        else if (b == CH_CR) parse_ph = PH_HEADER_CR;
        else raise_error(ERR_AFTER_HDR);
      end
      PH_HEADER_CR: begin
        if (b != CH_LF) raise_error(ERR_LONE_CR);
        else open_data();
      end
      PH_FIRST_LEAD: begin
        row_open = 1'b1;
        if (is_pad(b)) return;
        if (b == CH_MINUS) open_number(1'b1, PH_FIRST_NEED);
        else if (digit_byte(b)) begin
          open_number(1'b0, PH_FIRST_DIG);
          take_digit(b);
        end else if (b == CH_LF || b == CH_CR) raise_error(ERR_BLANK_LINE);
        else if (b == CH_COMMA) raise_error(ERR_MISSING_SRC);
        else if (b == CH_QUOTE) raise_error(ERR_QUOTE);
        else raise_error(ERR_INVALID_SRC);
      end
      PH_FIRST_NEED, PH_SECOND_NEED: begin
        if (!digit_byte(b)) raise_error(ERR_MINUS_ALONE);
        else begin
          if (parse_ph == PH_FIRST_NEED) parse_ph = PH_FIRST_DIG;
          else parse_ph = PH_SECOND_DIG;
          take_digit(b);
        end
      end
      PH_FIRST_DIG, PH_FIRST_TRAIL: begin
        if (parse_ph == PH_FIRST_DIG && digit_byte(b)) begin
          take_digit(b);
          return;
        end
        if (parse_ph == PH_FIRST_DIG) src_val = number_value();
        if (b == CH_COMMA) parse_ph = PH_SECOND_LEAD;
        else if (is_pad(b)) parse_ph = PH_FIRST_TRAIL;
        else if (b == CH_LF || b == CH_CR) raise_error(ERR_MISSING_DFLD);
        else raise_error(ERR_JUNK_SRC);
      end
      PH_SECOND_LEAD: begin
        if (is_pad(b)) return;
        if (b == CH_MINUS) open_number(1'b1, PH_SECOND_NEED);
        else if (digit_byte(b)) begin
          open_number(1'b0, PH_SECOND_DIG);
          take_digit(b);
        end else if (b == CH_COMMA) raise_error(ERR_EXTRA_FIELD);
        else if (b == CH_LF || b == CH_CR) raise_error(ERR_MISSING_DST);
        else if (b == CH_QUOTE) raise_error(ERR_QUOTE);
        else raise_error(ERR_INVALID_DST);
      end
      PH_SECOND_DIG, PH_SECOND_TRAIL: begin
        if (parse_ph == PH_SECOND_DIG && digit_byte(b)) begin
          take_digit(b);
          return;
        end
        if (parse_ph == PH_SECOND_DIG) dst_val = number_value();
        if (is_pad(b)) parse_ph = PH_SECOND_TRAIL;
        else if (b == CH_LF) close_line();
        else if (b == CH_CR) parse_ph = PH_ROW_CR;
        else if (b == CH_COMMA) raise_error(ERR_EXTRA_FIELD);
        else raise_error(ERR_JUNK_DST);
      end
      PH_ROW_CR: begin
        if (b != CH_LF) raise_error(ERR_LONE_CR);
        else close_line();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void parse_end();
    case (parse_ph)
      PH_HEADER: begin
        // Header text complete but no line break: empty input on line two
        if (hdr_idx >= HEADER_LEN) begin
          parse_ph = PH_FAILED;
          emit(KIND_ERROR, '0, '0, 32'd2, ERR_EMPTY, '0);
        end else raise_error(ERR_NO_HEADER);
      end
      PH_HEADER_CR, PH_ROW_CR: raise_error(ERR_LONE_CR);
      PH_FIRST_LEAD: begin
        if (row_open) raise_error(ERR_BAD_LAST);
        else if (row_no == 0) raise_error(ERR_EMPTY);
        else finish_run();
      end
      PH_FIRST_NEED, PH_SECOND_NEED: raise_error(ERR_MINUS_ALONE);
      PH_FIRST_DIG, PH_FIRST_TRAIL: raise_error(ERR_MISSING_DFLD);
      PH_SECOND_LEAD: raise_error(ERR_MISSING_DST);
      PH_SECOND_DIG, PH_SECOND_TRAIL: begin
        // Unterminated last row: edge first, then the summary
        if (parse_ph == PH_SECOND_DIG) dst_val = number_value();
        deliver_row();
        if (parse_ph != PH_FAILED) finish_run();
      end
      default: begin
      end
    endcase
  endfunction

  // Parse one accepted word and queue the results it must produce
  function automatic void parse_word(logic fin, logic [7:0] b);
    result_t r;
    if (parse_ph == PH_FINISHED || parse_ph == PH_FAILED) return;
    word_results.delete();
    if (fin == FUNC_END) parse_end();
    else parse_byte(b);
    if (word_results.size() > 0) begin
      r = word_results.pop_back();
      r.is_last = 1'b1;
      word_results.push_back(r);
    end
    foreach (word_results[i]) results_due.push_back(word_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual kind %0d line %0d",
                 $time, m_axis_tuser_o, m_axis_tdata_o[95:64]);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        compare_field("kind", 32'(want.kind), 32'(m_axis_tuser_o));
        compare_field("edge_from", want.edge_from, m_axis_tdata_o[31:0]);
        compare_field("edge_to", want.edge_to, m_axis_tdata_o[63:32]);
        compare_field("line_number", want.line_number, m_axis_tdata_o[95:64]);
        compare_field("error_code", 32'(want.error_code), 32'(m_axis_tdata_o[100:96]));
        compare_field("rows_delivered", want.rows_delivered, m_axis_tdata_o[132:101]);
        compare_field("is_last", 32'(want.is_last), 32'(m_axis_tlast_o));
        case (want.kind)
          KIND_EDGE:  edges_seen++;
          KIND_ERROR: errors_seen++;
          default:    summaries_seen++;
        endcase
      end
    end
  end

  // Hang detector: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("edge_pair_csv_parser verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result sink: hold tready low for a requested stretch, else stall at random
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word source; every task enters and leaves at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(logic fin, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fin;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    parse_word(fin, b);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(FUNC_BYTE, s[i]);
  endtask

  // Drop valid and wait for every predicted result to come out
  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic string pad_text();
    string s;
    s = "";
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1)) s = {s, " "};
        else s = {s, "\t"};
      end
    end
    return s;
  endfunction

  // Canonical decimal text, weighted toward the int32 extremes and small values
  function automatic string number_text();
    int v;
    case ($urandom_range(9))
      0:       v = 32'h7FFFFFFF;
      1:       v = 32'h80000000;
      2:       v = 0;
      3, 4, 5: v = int'($urandom_range(200)) - 100;
      default: v = int'($urandom);
    endcase
    return $sformatf("%0d", v);
  endfunction

  function automatic string random_row();
    string eol;
    if ($urandom_range(3) == 0) eol = "\r\n";
    else eol = "\n";
    return {pad_text(), number_text(), pad_text(), ",", pad_text(), number_text(), pad_text(),
            eol};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_header();
    send_text("from,to");
    if ($urandom_range(1)) send_text("\r\n");
    else send_text("\n");
  endtask

  task automatic test_extreme_row();
    send_text("2147483647,-2147483648\r\n");
  endtask

  task automatic test_random_rows(int unsigned idle, int unsigned stall, int unsigned budget);
    int unsigned first;
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    first = words_sent;
    while (words_sent - first < budget) send_text(random_row());
  endtask

  // Long sink hold-off while the source keeps offering rows: fill the queue
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = HOLD_OFF_CYCLES;
    repeat (8) send_text(random_row());
  endtask

  task automatic test_drain_pause();
    wait_results_drained();
    send_text(random_row());
  endtask

  // End the stream one way: clean end, unterminated row, or one of the violations
  task automatic test_termination();
    string      tail;
    logic       fin;
    logic [7:0] last_byte;
    tail      = "";
    fin       = FUNC_BYTE;
    last_byte = 8'($urandom_range(255));
    case ($urandom_range(19))
      0: fin = FUNC_END;
      1: begin
        tail = {number_text(), ",", number_text()};
        fin  = FUNC_END;
      end
      2: begin
        tail = {pad_text(), number_text(), " ,", pad_text(), number_text(), "\t"};
        fin  = FUNC_END;
      end
      3: last_byte = CH_QUOTE;
      4: begin
        tail      = {number_text(), ","};
        last_byte = CH_QUOTE;
      end
      5: last_byte = 8'($urandom_range(128, 255));
      6: begin
        tail      = number_text();
        last_byte = 8'($urandom_range(128, 255));
      end
      7: begin
        tail      = {number_text(), ","};
        last_byte = 8'($urandom_range(128, 255));
      end
      8: begin
        tail      = {number_text(), ",", number_text()};
        last_byte = 8'($urandom_range(128, 255));
      end
      9: last_byte = CH_LF;
      10: last_byte = CH_COMMA;
      11: begin
        tail = {number_text(), ",-"};
        if ($urandom_range(1)) fin = FUNC_END;
        else last_byte = CH_SP;
      end
      12: begin
        tail      = "-";
        last_byte = CH_ZERO;
      end
      13: begin
        tail      = "0";
        last_byte = 8'($urandom_range(CH_ZERO, CH_NINE));
      end
      14: begin
        if ($urandom_range(1)) tail = "2147483647";
        else tail = "-2147483648";
        last_byte = 8'($urandom_range(CH_ZERO, CH_NINE));
      end
      15: begin
        tail = {number_text(), ",", number_text(), "\r"};
        if ($urandom_range(1)) fin = FUNC_END;
        else last_byte = CH_SP;
      end
      16: begin
        if ($urandom_range(1)) tail = {number_text(), ",", number_text()};
        else tail = {number_text(), ","};
        last_byte = CH_COMMA;
      end
      17: begin
        tail = number_text();
        if ($urandom_range(1)) fin = FUNC_END;
        else last_byte = CH_LF;
      end
      18: begin
        tail = {number_text(), ","};
        if ($urandom_range(1)) fin = FUNC_END;
        else last_byte = CH_LF;
      end
      default: begin
        tail = pad_text();
        if (tail.len() == 0) tail = " ";
        fin = FUNC_END;
      end
    endcase
    send_text(tail);
    send_word(fin, last_byte);
    // Close any stream still open so the block ends up stopped
    if (parse_ph != PH_FINISHED && parse_ph != PH_FAILED)
      send_word(FUNC_END, 8'($urandom));
  endtask

  // Stopped block: any word, any byte, must be swallowed without a result
  task automatic test_stopped_block();
    repeat (40) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_header();
    test_extreme_row();
    test_random_rows(0, 0, PHASE_WORDS);
    test_random_rows(78, 0, PHASE_WORDS);
    test_random_rows(0, 78, PHASE_WORDS);
    test_backpressure();
    test_drain_pause();
    test_random_rows(33, 33, PHASE_WORDS);
    test_termination();
    test_stopped_block();

    wait_results_drained();
    repeat (8) @(posedge clk_i);

    $display("Run: %0d input words over four idle mixes, a %0d-cycle sink hold-off",
             words_sent, HOLD_OFF_CYCLES);
    $display("and a post-stop flood; checked %0d edges, %0d errors, %0d summaries.",
             edges_seen, errors_seen, summaries_seen);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("edge_pair_csv_parser verification clean");
    end else begin
      $display("edge_pair_csv_parser verification failed");
    end
    $finish;
  end

endmodule
